### rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned TIME_BITS  = 64;
  localparam int unsigned SECS_BITS  = 31;
  localparam int unsigned RATE_BITS  = 32;
  localparam int unsigned PROD_BITS  = SECS_BITS + RATE_BITS;
  localparam logic [RATE_BITS-1:0] TICK_RATE_RST = 32'd10000000;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_SERVICE = 1'b1;
  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] now;
    logic [SECS_BITS-1:0] delay_seconds;
    logic [TAG_BITS-1:0]  timer_tag;
    logic                 has_action;
  } in_item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [TAG_BITS-1:0]  fired_tag;
    logic [TIME_BITS-1:0] compare_time;
    logic                 compare_written;
    logic                 add_rejected;
    logic                 last;
  } out_item_t;

  // key is the expiry for an add and the sampled time for a service
  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] key;
    logic [TAG_BITS-1:0]  tag;
    logic                 act;
  } cmd_t;

endpackage

### rtl/core/sorted_timer_queue.sv
// channel  | ports                          | handshake
// ---------+--------------------------------+------------------------------
// input    | in_push, in_full, in_item      | item taken on push && !full
// result   | out_pop, out_empty, out_item   | item taken on pop && !empty
// config   | cfg_valid, cfg_ready, cfg_data | tick_rate written on valid
//
// An input item is registered in the multiply stage, then waits in a
// two-entry command queue. The back end retires an add from idle (parallel
// compare over all DEPTH slots); a service enters the serve state, removes
// each due timer in turn and ends with the status item; results queue in a
// two-entry output queue. rst_n (synchronous) empties both queues and the
// timer list, tick_rate returns to 10000000. A full result queue stalls the
// back end only; the front takes items until its stage and the cmd queue fill.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_item,
  output logic                 in_full,
  input  logic                 out_pop,
  output out_item_t            out_item,
  output logic                 out_empty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RATE_BITS-1:0] cfg_data
);

  // command path between front and back
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  // result path into the output queue
  logic      res_push, res_full;
  out_item_t res;

  // always take configuration writes
  assign cfg_ready = 1'b1;

  stq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  stq_fifo #(.WIDTH($bits(cmd_t)), .FDEPTH(QUEUE_DEPTH)) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_out),
    .empty    (cmd_empty)
  );

  // sorted timer list and its sequencer
  stq_back #(.DEPTH(DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  stq_fifo #(.WIDTH($bits(out_item_t)), .FDEPTH(QUEUE_DEPTH)) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_item),
    .empty    (out_empty)
  );

endmodule

### rtl/core/stq_fifo.sv
module stq_fifo
  import stq_pkg::*;
#(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned FDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned AW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int unsigned CW = $clog2(FDEPTH + 1);

  logic [WIDTH-1:0] mem [FDEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(FDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(FDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(FDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/stq_front.sv
module stq_front
  import stq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_item,
  output logic                 in_full,
  input  logic                 cfg_valid,
  input  logic [RATE_BITS-1:0] cfg_data,
  output logic                 cmd_push,
  output cmd_t                 cmd,
  input  logic                 cmd_full
);

  logic [RATE_BITS-1:0] rate_r;
  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [PROD_BITS-1:0] s1_prod_r;
  logic [TAG_BITS-1:0]  s1_tag_r;
  logic                 s1_act_r;
  logic                 take;

  assign in_full  = s1_valid_r && cmd_full;
  assign take     = in_push && !in_full;
  assign cmd_push = s1_valid_r && !cmd_full;

  always_comb begin
    cmd.operation = s1_op_r;
    cmd.key       = (s1_op_r == OP_ADD) ? s1_now_r + TIME_BITS'(s1_prod_r) : s1_now_r;
    cmd.tag       = s1_tag_r;
    cmd.act       = s1_act_r;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r   <= in_item.operation;
      s1_now_r  <= in_item.now;
      s1_prod_r <= PROD_BITS'(in_item.delay_seconds) * PROD_BITS'(rate_r);
      s1_tag_r  <= in_item.timer_tag;
      s1_act_r  <= in_item.has_action;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rate_r     <= TICK_RATE_RST;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (cmd_push) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        rate_r <= cfg_data;
      end
    end
  end

endmodule

### rtl/core/stq_back.sv
module stq_back
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_SERVE} state_t;

  state_t               st_r, st_nxt;
  logic [TIME_BITS-1:0] exp_r [DEPTH];
  logic [TAG_BITS-1:0]  tag_r [DEPTH];
  logic                 act_r [DEPTH];
  logic [CW-1:0]        count_r, count_nxt;
  logic [DEPTH-1:0]     ge;
  logic                 do_ins, do_pop, q_full, head_due;
  logic [TIME_BITS-1:0] head_cmp;

  assign q_full   = (count_r == CW'(DEPTH));
  assign head_cmp = (count_r != '0) ? exp_r[0] : '1;
  assign head_due = (count_r != '0) && (exp_r[0] <= cmd.key);

  // ge[i]: slot i takes the new entry or its lower neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = ((CW'(i) < count_r) && (cmd.key < exp_r[i])) || (CW'(i) == count_r);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          if (cmd.operation == OP_ADD) begin
            res_push         = 1'b1;
            cmd_pop          = 1'b1;
            res.result_kind  = KIND_STATUS;
            res.last         = 1'b1;
            if (q_full) begin
              res.add_rejected = 1'b1;
              res.compare_time = head_cmp;
            end else begin
              do_ins              = 1'b1;
              count_nxt           = count_r + 1'b1;
              res.compare_written = ge[0];
              res.compare_time    = ge[0] ? cmd.key : exp_r[0];
            end
          end else begin
            st_nxt = ST_SERVE;
          end
        end
      end
      ST_SERVE: begin
        if (!res_full) begin
          if (head_due) begin
            do_pop    = 1'b1;
            count_nxt = count_r - 1'b1;
            if (act_r[0]) begin
              res_push        = 1'b1;
              res.result_kind = KIND_FIRED;
              res.fired_tag   = tag_r[0];
            end
          end else begin
            res_push            = 1'b1;
            cmd_pop             = 1'b1;
            res.result_kind     = KIND_STATUS;
            res.compare_time    = head_cmp;
            res.compare_written = 1'b1;
            res.last            = 1'b1;
            st_nxt              = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins && ge[i]) begin
        if (i == 0 || !ge[(i == 0) ? 0 : i - 1]) begin
          exp_r[i] <= cmd.key;
          tag_r[i] <= cmd.tag;
          act_r[i] <= cmd.act;
        end else begin
          exp_r[i] <= exp_r[(i == 0) ? 0 : i - 1];
          tag_r[i] <= tag_r[(i == 0) ? 0 : i - 1];
          act_r[i] <= act_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_pop && (i < DEPTH - 1)) begin
        exp_r[i] <= exp_r[(i < DEPTH - 1) ? i + 1 : i];
        tag_r[i] <= tag_r[(i < DEPTH - 1) ? i + 1 : i];
        act_r[i] <= act_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_status_ends_service: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SERVE && res_push && res.result_kind == KIND_STATUS) |=> st_r == ST_IDLE)
    else $error("service did not finish after status");

  a_pop_only_due: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (st_r == ST_SERVE && count_r != '0))
    else $error("head removed outside service");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_ins && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the queue");

endmodule
